FILE: src/bpa_pkg.sv
// bpa_pkg: sizes, codes, memory request types and helper functions of the
// buddy page allocator; used by the channel interfaces and every module.
`default_nettype none

package bpa_pkg;

    // region geometry
    localparam int PAGES     = 1024;
    localparam int TOP_ORDER = 10;
    localparam int PAGE_W    = 10;   // page index
    localparam int CNT_W     = 11;   // page counts, links (with the empty code)
    localparam int LINK_W    = 11;
    localparam int ORD_W     = 4;
    localparam int ROW_W     = 32;   // head flags packed per memory row
    localparam int BIT_AW    = 5;
    localparam int ROW_AW    = PAGE_W - BIT_AW;
    localparam int ROWS      = PAGES / ROW_W;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGES);

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NO_BLOCK = 2'd1;
    localparam logic [1:0] STAT_BAD      = 2'd2;

    // one entry of the link memory
    typedef struct packed {
        logic [ORD_W-1:0]  ord;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_link;

    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        t_link             wr_data;
    } t_link_req;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_AW-1:0] rd_row;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_page;
        logic              wr_set;
        logic              clr_all;
    } t_head_req;

    // smallest order whose block holds cnt pages
    function automatic logic [ORD_W-1:0] f_alloc_order(input logic [CNT_W-1:0] cnt);
        logic [ORD_W-1:0] ord;
        ord = '0;
        for (int i = 0; i < TOP_ORDER; i++) begin
            if ((CNT_W'(1) << i) < cnt) begin
                ord = ORD_W'(i + 1);
            end
        end
        return ord;
    endfunction

    // largest aligned block at base that fits in n pages
    function automatic logic [ORD_W-1:0] f_block_order(input logic [CNT_W-1:0] base,
                                                       input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int i = 1; i <= TOP_ORDER; i++) begin
            if ((base & ((CNT_W'(1) << i) - CNT_W'(1))) == '0 &&
                (CNT_W'(1) << i) <= n) begin
                k = ORD_W'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: src/bpa_ifs.sv
// bpa_ifs: valid/ready channels of the allocator (request, response, config)
// depends on bpa_pkg for field widths
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [PAGE_W-1:0] base_page;
    logic [CNT_W-1:0]  req_pages;

    modport source (output valid, operation, base_page, req_pages, input ready);
    modport sink   (input valid, operation, base_page, req_pages, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  pages_free;

    modport source (output valid, status, first_page, pages_free, input ready);
    modport sink   (input valid, status, first_page, pages_free, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] region_pages;

    modport source (output valid, region_pages, input ready);
    modport sink   (input valid, region_pages, output ready);
endinterface

`default_nettype wire

FILE: src/bpa_head_mem.sv
// bpa_head_mem: free-block head flags, 32 per memory row, with a valid bit
// per row so that a clear resets only the valid bits; depends on bpa_pkg
`default_nettype none

module bpa_head_mem import bpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_head_req        i_req,
    output logic [ROW_W-1:0] o_rd_row
);

    logic [ROW_W-1:0]  r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic              r_rd_vld;
    logic [ROW_W-1:0]  r_rd_data;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_bit;
    logic [ROW_W-1:0]  wr_mask;
    logic [ROW_W-1:0]  wr_data;

    // a row never written since the last clear is rewritten whole
    assign wr_row  = i_req.wr_page[PAGE_W-1:BIT_AW];
    assign wr_bit  = ROW_W'(1) << i_req.wr_page[BIT_AW-1:0];
    assign wr_mask = r_row_vld[wr_row] ? wr_bit : '1;
    assign wr_data = i_req.wr_set ? wr_bit : '0;

    // row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.clr_all) begin
                r_row_vld <= '0;
            end else if (i_req.wr_en) begin
                r_row_vld[wr_row] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_row];
            end
        end
    end

    // flag memory, bit-masked write, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            for (int i = 0; i < ROW_W; i++) begin
                if (wr_mask[i]) begin
                    r_mem[wr_row][i] <= wr_data[i];
                end
            end
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_row];
        end
    end

    // stale rows read as all clear
    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: src/bpa_link_mem.sv
// bpa_link_mem: per-page order and list links of free blocks
// one write and one read port, registered read; depends on bpa_pkg
`default_nettype none

module bpa_link_mem import bpa_pkg::*; (
    input  logic      i_clk,
    input  t_link_req i_req,
    output t_link     o_rd_data
);

    t_link r_mem [PAGES];
    t_link r_rd_data;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/bpa_ctrl.sv
// bpa_ctrl: request sequencer of the buddy allocator: search, split, merge,
// list push/unlink and double-free check; drives both memories; bpa_pkg, bpa_ifs
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpa_req_if.sink          i_req,
    bpa_rsp_if.source        o_rsp,
    input  logic [CNT_W-1:0] i_region_pages,
    output t_head_req        o_head_req,
    input  logic [ROW_W-1:0] i_head_row,
    output t_link_req        o_link_req,
    input  t_link            i_link_rd
);

    typedef enum logic [17:0] {
        S_IDLE       = 18'h00001,
        S_CHK_ROW_RD = 18'h00002,
        S_CHK_ROW_EV = 18'h00004,
        S_CHK_COV_RD = 18'h00008,
        S_CHK_COV_EV = 18'h00010,
        S_ALC_RD     = 18'h00020,
        S_ALC_EV     = 18'h00040,
        S_SPLIT      = 18'h00080,
        S_FR_STEP    = 18'h00100,
        S_MRG_RD     = 18'h00200,
        S_MRG_EV     = 18'h00400,
        S_UNL_A      = 18'h00800,
        S_UNL_QW     = 18'h01000,
        S_UNL_NR     = 18'h02000,
        S_UNL_NW     = 18'h04000,
        S_PSH_A      = 18'h08000,
        S_PSH_HW     = 18'h10000,
        S_DONE       = 18'h20000
    } t_state;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_list_head [TOP_ORDER+1];
    logic [LINK_W-1:0] n_list_head [TOP_ORDER+1];
    logic [CNT_W-1:0]  r_free_total, n_free_total;
    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [PAGE_W-1:0] r_o_index, n_o_index;
    logic [CNT_W-1:0]  r_o_free, n_o_free;

    logic [CNT_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ORD_W-1:0]  r_order, n_order;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [PAGE_W-1:0] r_p, n_p;
    logic [PAGE_W-1:0] r_bud, n_bud;
    logic [LINK_W-1:0] r_nx, n_nx;
    logic [LINK_W-1:0] r_pv, n_pv;
    logic [CNT_W-1:0]  r_alloc_cnt, n_alloc_cnt;
    logic              r_alloc, n_alloc;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [PAGE_W-1:0] r_last, n_last;
    logic [1:0]        r_res_status, n_res_status;
    logic [PAGE_W-1:0] r_res_index, n_res_index;

    logic [CNT_W-1:0]  lim;
    logic              accept;

    assign lim    = (i_region_pages > CNT_W'(PAGES)) ? CNT_W'(PAGES) : i_region_pages;
    assign accept = i_req.valid && i_req.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.first_page = r_o_index;
    assign o_rsp.pages_free = r_o_free;

    // sequencer
    always_comb begin
        logic [ORD_W-1:0]  a_order;
        logic [ORD_W-1:0]  a_c;
        logic              a_found;
        logic [ORD_W-1:0]  fk;
        logic [ORD_W-1:0]  k_dn;
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] bud;
        logic [BIT_AW-1:0] lo;
        logic [BIT_AW-1:0] hi;
        logic [ROW_W-1:0]  row_mask;
        logic              unl_ret;
        logic              psh_ret;

        n_state      = r_state;
        n_list_head  = r_list_head;
        n_free_total = r_free_total;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_index    = r_o_index;
        n_o_free     = r_o_free;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_order      = r_order;
        n_k          = r_k;
        n_p          = r_p;
        n_bud        = r_bud;
        n_nx         = r_nx;
        n_pv         = r_pv;
        n_alloc_cnt  = r_alloc_cnt;
        n_alloc      = r_alloc;
        n_row        = r_row;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        o_head_req   = '0;
        o_link_req   = '0;
        unl_ret      = 1'b0;
        psh_ret      = 1'b0;

        // lowest non-empty order at or above the request's order
        a_order = f_alloc_order(i_req.req_pages);
        a_c     = '0;
        a_found = 1'b0;
        for (int i = TOP_ORDER; i >= 0; i--) begin
            if (ORD_W'(i) >= a_order && r_list_head[i] != NIL) begin
                a_c     = ORD_W'(i);
                a_found = 1'b1;
            end
        end

        fk   = f_block_order(r_base, r_cnt);
        k_dn = r_k - ORD_W'(1);
        pg   = r_list_head[r_k][PAGE_W-1:0];
        bud  = r_p ^ (PAGE_W'(1) << r_k);

        // range mask of the head-flag row under scan
        lo       = (r_row == r_base[PAGE_W-1:BIT_AW]) ? r_base[BIT_AW-1:0] : '0;
        hi       = (r_row == r_last[PAGE_W-1:BIT_AW]) ? r_last[BIT_AW-1:0] : '1;
        row_mask = ({ROW_W{1'b1}} << lo) & ({ROW_W{1'b1}} >> (BIT_AW'(ROW_W - 1) - hi));

        // output register drains independently
        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = STAT_DONE;
                    n_res_index  = '0;
                    n_alloc      = 1'b0;
                    case (i_req.operation)
                        OP_ALLOC: begin
                            if (i_req.req_pages == '0 ||
                                i_req.req_pages > CNT_W'(1 << TOP_ORDER)) begin
                                n_res_status = STAT_BAD;
                                n_state      = S_DONE;
                            end else if (!a_found) begin
                                n_res_status = STAT_NO_BLOCK;
                                n_state      = S_DONE;
                            end else begin
                                n_k         = a_c;
                                n_order     = a_order;
                                n_alloc_cnt = i_req.req_pages;
                                n_alloc     = 1'b1;
                                n_state     = S_ALC_RD;
                            end
                        end
                        OP_FREE: begin
                            if (i_req.req_pages == '0 ||
                                (12'(i_req.base_page) + 12'(i_req.req_pages)) > 12'(lim))
                            begin
                                n_res_status = STAT_BAD;
                                n_state      = S_DONE;
                            end else begin
                                n_base  = CNT_W'(i_req.base_page);
                                n_cnt   = i_req.req_pages;
                                n_row   = i_req.base_page[PAGE_W-1:BIT_AW];
                                n_last  = PAGE_W'(CNT_W'(i_req.base_page) + i_req.req_pages
                                                  - CNT_W'(1));
                                n_k     = ORD_W'(1);
                                n_state = S_CHK_ROW_RD;
                            end
                        end
                        OP_INIT: begin
                            o_head_req.clr_all = 1'b1;
                            for (int i = 0; i <= TOP_ORDER; i++) begin
                                n_list_head[i] = NIL;
                            end
                            n_free_total = '0;
                            n_base       = '0;
                            n_cnt        = lim;
                            n_state      = S_FR_STEP;
                        end
                        default: begin
                            n_res_status = STAT_BAD;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end

            // double-free check: any head flag inside the range
            S_CHK_ROW_RD: begin
                o_head_req.rd_en  = 1'b1;
                o_head_req.rd_row = r_row;
                n_state           = S_CHK_ROW_EV;
            end
            S_CHK_ROW_EV: begin
                if ((i_head_row & row_mask) != '0) begin
                    n_res_status = STAT_BAD;
                    n_state      = S_DONE;
                end else if (r_row == r_last[PAGE_W-1:BIT_AW]) begin
                    n_state = S_CHK_COV_RD;
                end else begin
                    n_row   = r_row + ROW_AW'(1);
                    n_state = S_CHK_ROW_RD;
                end
            end

            // double-free check: a free block that starts below and covers base
            S_CHK_COV_RD: begin
                n_bud              = r_base[PAGE_W-1:0] & ~((PAGE_W'(1) << r_k) - PAGE_W'(1));
                o_head_req.rd_en   = 1'b1;
                o_head_req.rd_row  = n_bud[PAGE_W-1:BIT_AW];
                o_link_req.rd_en   = 1'b1;
                o_link_req.rd_addr = n_bud;
                n_state            = S_CHK_COV_EV;
            end
            S_CHK_COV_EV: begin
                if (i_head_row[r_bud[BIT_AW-1:0]] && i_link_rd.ord == r_k) begin
                    n_res_status = STAT_BAD;
                    n_state      = S_DONE;
                end else if (r_k == ORD_W'(TOP_ORDER)) begin
                    n_state = S_FR_STEP;
                end else begin
                    n_k     = r_k + ORD_W'(1);
                    n_state = S_CHK_COV_RD;
                end
            end

            // allocate: fetch links of the front block
            S_ALC_RD: begin
                n_bud              = pg;
                n_res_index        = pg;
                o_link_req.rd_en   = 1'b1;
                o_link_req.rd_addr = pg;
                n_state            = S_ALC_EV;
            end
            S_ALC_EV: begin
                n_nx    = i_link_rd.nxt;
                n_pv    = i_link_rd.prv;
                n_state = S_UNL_A;
            end

            // split down to the request order, then free the unused tail
            S_SPLIT: begin
                if (r_k > r_order) begin
                    n_k     = k_dn;
                    n_p     = r_res_index + (PAGE_W'(1) << k_dn);
                    n_state = S_PSH_A;
                end else begin
                    n_alloc = 1'b0;
                    n_base  = CNT_W'(r_res_index) + r_alloc_cnt;
                    n_cnt   = (CNT_W'(1) << r_order) - r_alloc_cnt;
                    n_state = S_FR_STEP;
                end
            end

            // range free: next maximal aligned block
            S_FR_STEP: begin
                if (r_cnt == '0) begin
                    n_res_status = STAT_DONE;
                    n_state      = S_DONE;
                end else begin
                    n_p     = r_base[PAGE_W-1:0];
                    n_k     = fk;
                    n_base  = r_base + (CNT_W'(1) << fk);
                    n_cnt   = r_cnt - (CNT_W'(1) << fk);
                    n_state = S_MRG_RD;
                end
            end

            // merge with the buddy while it is free and inside the region
            S_MRG_RD: begin
                if (r_k >= ORD_W'(TOP_ORDER) || CNT_W'(bud) >= lim) begin
                    n_state = S_PSH_A;
                end else begin
                    n_bud              = bud;
                    o_head_req.rd_en   = 1'b1;
                    o_head_req.rd_row  = bud[PAGE_W-1:BIT_AW];
                    o_link_req.rd_en   = 1'b1;
                    o_link_req.rd_addr = bud;
                    n_state            = S_MRG_EV;
                end
            end
            S_MRG_EV: begin
                if (i_head_row[r_bud[BIT_AW-1:0]] && i_link_rd.ord == r_k) begin
                    n_nx    = i_link_rd.nxt;
                    n_pv    = i_link_rd.prv;
                    n_state = S_UNL_A;
                end else begin
                    n_state = S_PSH_A;
                end
            end

            // unlink r_bud from list r_k
            S_UNL_A: begin
                o_head_req.wr_en   = 1'b1;
                o_head_req.wr_page = r_bud;
                o_head_req.wr_set  = 1'b0;
                n_free_total       = r_free_total - (CNT_W'(1) << r_k);
                if (r_pv != NIL) begin
                    o_link_req.rd_en   = 1'b1;
                    o_link_req.rd_addr = r_pv[PAGE_W-1:0];
                    n_state            = S_UNL_QW;
                end else begin
                    n_list_head[r_k] = r_nx;
                    n_state          = S_UNL_NR;
                end
            end
            S_UNL_QW: begin
                o_link_req.wr_en       = 1'b1;
                o_link_req.wr_addr     = r_pv[PAGE_W-1:0];
                o_link_req.wr_data     = i_link_rd;
                o_link_req.wr_data.nxt = r_nx;
                n_state                = S_UNL_NR;
            end
            S_UNL_NR: begin
                if (r_nx != NIL) begin
                    o_link_req.rd_en   = 1'b1;
                    o_link_req.rd_addr = r_nx[PAGE_W-1:0];
                    n_state            = S_UNL_NW;
                end else begin
                    unl_ret = 1'b1;
                end
            end
            S_UNL_NW: begin
                o_link_req.wr_en       = 1'b1;
                o_link_req.wr_addr     = r_nx[PAGE_W-1:0];
                o_link_req.wr_data     = i_link_rd;
                o_link_req.wr_data.prv = r_pv;
                unl_ret                = 1'b1;
            end

            // push r_p at the front of list r_k
            S_PSH_A: begin
                o_link_req.wr_en       = 1'b1;
                o_link_req.wr_addr     = r_p;
                o_link_req.wr_data.ord = r_k;
                o_link_req.wr_data.nxt = r_list_head[r_k];
                o_link_req.wr_data.prv = NIL;
                o_head_req.wr_en       = 1'b1;
                o_head_req.wr_page     = r_p;
                o_head_req.wr_set      = 1'b1;
                n_list_head[r_k]       = LINK_W'(r_p);
                n_free_total           = r_free_total + (CNT_W'(1) << r_k);
                if (r_list_head[r_k] != NIL) begin
                    n_nx               = r_list_head[r_k];
                    o_link_req.rd_en   = 1'b1;
                    o_link_req.rd_addr = r_list_head[r_k][PAGE_W-1:0];
                    n_state            = S_PSH_HW;
                end else begin
                    psh_ret = 1'b1;
                end
            end
            S_PSH_HW: begin
                o_link_req.wr_en       = 1'b1;
                o_link_req.wr_addr     = r_nx[PAGE_W-1:0];
                o_link_req.wr_data     = i_link_rd;
                o_link_req.wr_data.prv = LINK_W'(r_p);
                psh_ret                = 1'b1;
            end

            // hand the result to the output register
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_index  = (r_res_status == STAT_DONE) ? r_res_index : '0;
                    n_o_free   = r_free_total;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // return from unlink: continue the split or climb one merge level
        if (unl_ret) begin
            if (r_alloc) begin
                n_state = S_SPLIT;
            end else begin
                n_p     = r_p & ~(PAGE_W'(1) << r_k);
                n_k     = r_k + ORD_W'(1);
                n_state = S_MRG_RD;
            end
        end

        // return from push
        if (psh_ret) begin
            n_state = r_alloc ? S_SPLIT : S_FR_STEP;
        end
    end

    // control and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_total <= '0;
            r_o_valid    <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++) begin
                r_list_head[i] <= NIL;
            end
        end else begin
            r_state      <= n_state;
            r_free_total <= n_free_total;
            r_o_valid    <= n_o_valid;
            r_list_head  <= n_list_head;
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_o_status   <= n_o_status;
        r_o_index    <= n_o_index;
        r_o_free     <= n_o_free;
        r_base       <= n_base;
        r_cnt        <= n_cnt;
        r_order      <= n_order;
        r_k          <= n_k;
        r_p          <= n_p;
        r_bud        <= n_bud;
        r_nx         <= n_nx;
        r_pv         <= n_pv;
        r_alloc_cnt  <= n_alloc_cnt;
        r_alloc      <= n_alloc;
        r_row        <= n_row;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
    end

    // link memory is never read and written at one entry in the same cycle
    a_link_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_link_req.rd_en && o_link_req.wr_en |-> o_link_req.rd_addr != o_link_req.wr_addr)
        else $error("link memory read and write hit the same entry");

    // a head-flag row is never read while it is being written
    a_head_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_req.rd_en && o_head_req.wr_en
            |-> o_head_req.rd_row != o_head_req.wr_page[PAGE_W-1:BIT_AW])
        else $error("head row read and written in the same cycle");

    // one item at a time: the request side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request accepted while another was in progress");

    // the old front block that gets a back link is a real page
    a_push_link_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PSH_HW |-> r_nx != NIL)
        else $error("push patched the empty-list code");

endmodule

`default_nettype wire

FILE: src/buddy_page_allocator_core.sv
// Binary buddy page allocator over a region of up to 1024 pages. One request
// is worked on at a time, with an output register so the next request can be
// accepted while a result waits. Allocate finds and unlinks a block, splits
// it level by level, then frees the unused tail. Free scans each 32-page
// head-flag row the range spans, runs the covering-block check, then per
// aligned block cuts it and climbs merge levels while the buddy is free,
// stopping when the buddy lies outside the region or the top order is
// reached; each merged buddy is unlinked and the final block is pushed.
// Every request ends by handing the result to the output register.
// Initialize clears all lists at once (no clearing pass) and then frees the
// region. The sequence is set by the one-read, one-write link memory and its
// registered read, through which every list update is read, modified and
// written back.
// depends on bpa_pkg, bpa_ifs, bpa_head_mem, bpa_link_mem, bpa_ctrl
`default_nettype none

module buddy_page_allocator_core import bpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp,
    bpa_cfg_if.sink   i_cfg
);

    logic [CNT_W-1:0] r_region_pages;
    t_head_req        head_req;
    logic [ROW_W-1:0] head_row;
    t_link_req        link_req;
    t_link            link_rd;

    // region size register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_pages <= CNT_W'(PAGES);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_region_pages <= i_cfg.region_pages;
        end
    end

    bpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .i_region_pages (r_region_pages),
        .o_head_req     (head_req),
        .i_head_row     (head_row),
        .o_link_req     (link_req),
        .i_link_rd      (link_rd)
    );

    bpa_head_mem u_head_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (head_req),
        .o_rd_row (head_row)
    );

    bpa_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_req     (link_req),
        .o_rd_data (link_rd)
    );

endmodule

`default_nettype wire

FILE: tb/bpa_tb_scoreboard.sv
// buddy allocator result tracker: predicts free-list state per request item
// and compares response items in order; depends on bpa_pkg
`timescale 1ns / 1ps

import bpa_pkg::*;

class bpa_alloc_tracker;

    bit               head_set [PAGES];
    bit [ORD_W-1:0]   blk_ord  [PAGES];
    bit [LINK_W-1:0]  nxt_pg   [PAGES];
    bit [LINK_W-1:0]  prv_pg   [PAGES];
    bit [LINK_W-1:0]  front    [TOP_ORDER+1];
    int unsigned      free_cnt;
    int unsigned      region;
    logic [1:0]       exp_status [$];
    logic [PAGE_W-1:0] exp_index [$];
    logic [CNT_W-1:0] exp_free   [$];
    int               mismatches;

    function new();
        clear_lists();
        region = PAGES;
        mismatches = 0;
    endfunction

    function void clear_lists();
        for (int p = 0; p < PAGES; p++) begin
            head_set[p] = 0;
            blk_ord[p] = 0;
            nxt_pg[p] = 0;
            prv_pg[p] = 0;
        end
        for (int k = 0; k <= TOP_ORDER; k++) front[k] = NIL;
        free_cnt = 0;
    endfunction

    function int unsigned limit();
        return (region > PAGES) ? PAGES : region;
    endfunction

    function void set_region(int unsigned v);
        region = v;
    endfunction

    function void push_blk(int k, int unsigned p);
        int unsigned h;
        h = front[k];
        nxt_pg[p] = LINK_W'(h);
        prv_pg[p] = NIL;
        if (h < PAGES) prv_pg[h] = LINK_W'(p);
        front[k] = LINK_W'(p);
        head_set[p] = 1;
        blk_ord[p] = ORD_W'(k);
        free_cnt += 1 << k;
    endfunction

    function void unlink_blk(int k, int unsigned p);
        int unsigned n, q;
        n = nxt_pg[p];
        q = prv_pg[p];
        if (q < PAGES) nxt_pg[q] = LINK_W'(n);
        else front[k] = LINK_W'(n);
        if (n < PAGES) prv_pg[n] = LINK_W'(q);
        head_set[p] = 0;
        free_cnt -= 1 << k;
    endfunction

    function void release_blk(int unsigned p, int k);
        int unsigned b;
        while (k < TOP_ORDER) begin
            b = p ^ (1 << k);
            if (b >= limit() || !head_set[b] || blk_ord[b] != k) break;
            unlink_blk(k, b);
            p &= ~(1 << k);
            k++;
        end
        push_blk(k, p);
    endfunction

    function void release_range(int unsigned base, int unsigned n);
        int k;
        while (n != 0) begin
            k = TOP_ORDER;
            while (k > 0 && ((base & ((1 << k) - 1)) != 0 || (1 << k) > n)) k--;
            release_blk(base, k);
            base += 1 << k;
            n -= 1 << k;
        end
    endfunction

    function bit page_free(int unsigned p);
        int unsigned h;
        for (int k = 0; k <= TOP_ORDER; k++) begin
            h = p & ~((1 << k) - 1);
            if (head_set[h] && blk_ord[h] == k) return 1;
        end
        return 0;
    endfunction

    // note one accepted request item
    function void note_request(logic [1:0] op, logic [PAGE_W-1:0] base,
                               logic [CNT_W-1:0] cnt);
        logic [1:0] st;
        int unsigned idx, ord, pg, c;
        st = STAT_DONE;
        idx = 0;
        if (op == OP_ALLOC) begin
            if (cnt == 0 || cnt > (1 << TOP_ORDER)) st = STAT_BAD;
            else begin
                ord = 0;
                while ((1 << ord) < cnt) ord++;
                st = STAT_NO_BLOCK;
                for (c = ord; c <= TOP_ORDER; c++) begin
                    pg = front[c];
                    if (pg < PAGES) begin
                        unlink_blk(c, pg);
                        while (c > ord) begin
                            c--;
                            push_blk(c, pg + (1 << c));
                        end
                        if (cnt < (1 << ord)) release_range(pg + cnt, (1 << ord) - cnt);
                        idx = pg;
                        st = STAT_DONE;
                        break;
                    end
                end
            end
        end else if (op == OP_FREE) begin
            if (cnt == 0 || base + cnt > limit()) st = STAT_BAD;
            else begin
                for (int unsigned p = base; p < base + cnt; p++) begin
                    if (page_free(p)) begin
                        st = STAT_BAD;
                        break;
                    end
                end
                if (st == STAT_DONE) release_range(base, cnt);
            end
        end else if (op == OP_INIT) begin
            clear_lists();
            release_range(0, limit());
        end else st = STAT_BAD;
        exp_status.push_back(st);
        exp_index.push_back(idx[PAGE_W-1:0]);
        exp_free.push_back(free_cnt[CNT_W-1:0]);
    endfunction

    // compare one response item with the oldest prediction
    function void check_response(logic [1:0] st, logic [PAGE_W-1:0] idx,
                                 logic [CNT_W-1:0] fp);
        if (exp_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response st=%0d idx=%0d free=%0d",
                                           st, idx, fp);
            return;
        end
        if (st !== exp_status[0] || idx !== exp_index[0] || fp !== exp_free[0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d idx=%0d free=%0d, got st=%0d idx=%0d free=%0d",
                         exp_status[0], exp_index[0], exp_free[0], st, idx, fp);
        end
        void'(exp_status.pop_front());
        void'(exp_index.pop_front());
        void'(exp_free.pop_front());
    endfunction

    function int pending();
        return exp_status.size();
    endfunction
endclass

FILE: tb/testbench.sv
// top of the allocator testbench: drives request and config channels,
// stalls the response channel; depends on bpa_pkg, bpa_ifs, the tracker class
`timescale 1ns / 1ps

module testbench import bpa_pkg::*; ();

    localparam int CYCLE_LIMIT = 5000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    longint cycles = 0;
    bpa_alloc_tracker tracker;

    bpa_req_if req_ch();
    bpa_rsp_if rsp_ch();
    bpa_cfg_if cfg_ch();

    buddy_page_allocator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0;
        req_ch.operation = OP_ALLOC;
        req_ch.base_page = 0;
        req_ch.req_pages = 1;
        cfg_ch.valid = 0;
        cfg_ch.region_pages = 0;
        rsp_ch.ready = 0;
        tracker = new();
    end

    // response side: random stall, check each accepted item
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("buddy_page_allocator_core test failed");
            $finish;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.status, rsp_ch.first_page, rsp_ch.pages_free);
        rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // send one request item, with random idle cycles before it
    task automatic send_request(logic [1:0] op, logic [PAGE_W-1:0] base,
                                logic [CNT_W-1:0] cnt);
        if ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.operation <= op;
        req_ch.base_page <= base;
        req_ch.req_pages <= cnt;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(op, base, cnt);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // region write while idle
    task automatic write_region(int unsigned v);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.region_pages <= CNT_W'(v);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
        tracker.set_region(v);
    endtask

    // random request: mostly well-formed allocate/free traffic
    task automatic random_request(ref int unsigned held_base[$], ref int unsigned held_cnt[$]);
        int unsigned r, j, c;
        logic [1:0] op;
        r = $urandom_range(99);
        if (r < 45) begin
            c = ($urandom_range(9) == 0) ? $urandom_range(1024, 1) : $urandom_range(40, 1);
            if ($urandom_range(49) == 0) c = $urandom_range(2047, 1025);
            op = OP_ALLOC;
            send_request(op, PAGE_W'($urandom), CNT_W'(c));
            if (tracker.exp_status[$] == STAT_DONE && tracker.exp_index.size() > 0) begin
                held_base.push_back(tracker.exp_index[$]);
                held_cnt.push_back(c);
            end
        end else if (r < 85 && held_base.size() > 0) begin
            j = $urandom_range(held_base.size() - 1);
            send_request(OP_FREE, PAGE_W'(held_base[j]), CNT_W'(held_cnt[j]));
            held_base.delete(j);
            held_cnt.delete(j);
        end else if (r < 95) begin
            send_request(OP_FREE, PAGE_W'($urandom), CNT_W'($urandom_range(2047)));
        end else if (r < 98) begin
            send_request(OP_INIT, PAGE_W'($urandom), CNT_W'($urandom));
            held_base.delete();
            held_cnt.delete();
        end else begin
            send_request(OP_RSVD, PAGE_W'($urandom), CNT_W'($urandom));
        end
    endtask

    initial begin
        int unsigned held_base[$];
        int unsigned held_cnt[$];
        int unsigned regions[6];
        regions = '{1024, 1, 2047, 777, 13, 1025};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty-pool cases, extremes, double free, bad op
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 0, 1025);
        send_request(OP_ALLOC, 10'h3ff, 11'h7ff);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 10'h3ff, 2);
        send_request(OP_FREE, 0, 1024);
        send_request(OP_FREE, 5, 1);
        send_request(OP_ALLOC, 0, 1024);
        send_request(OP_INIT, 0, 0);
        send_request(OP_ALLOC, 0, 3);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_ALLOC, 0, 700);
        send_request(OP_FREE, 0, 3);
        send_request(OP_FREE, 1, 1);
        send_request(OP_FREE, 3, 1);
        send_request(OP_FREE, 10'h3ff, 1);
        send_request(OP_RSVD, 10'h3ff, 11'h7ff);
        send_request(OP_INIT, 10'h2aa, 11'h555);

        // pause until all results are back
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_region(regions[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0; snk_stall_pct = 0; end
                1: begin src_idle_pct = 46; snk_stall_pct = 0; end
                2: begin src_idle_pct = 0; snk_stall_pct = 46; end
                default: begin src_idle_pct = 7; snk_stall_pct = 7; end
            endcase
            send_request(OP_INIT, 0, 0);
            held_base.delete();
            held_cnt.delete();
            for (int n = 0; n < 190; n++) random_request(held_base, held_cnt);
        end

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("buddy_page_allocator_core test passed");
        end else begin
            $display("buddy_page_allocator_core test failed");
        end
        $finish;
    end
endmodule

FILE: buddy_page_allocator_core.f
src/bpa_pkg.sv
src/bpa_ifs.sv
src/bpa_head_mem.sv
src/bpa_link_mem.sv
src/bpa_ctrl.sv
src/buddy_page_allocator_core.sv
tb/bpa_tb_scoreboard.sv
tb/testbench.sv
